FILE: hdl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`default_nettype none
package modexp_pkg;

	// fixed field widths
	localparam int BASE_W = 31;
	localparam int RES_W  = 31;
	// multiplier scans BASE_W multiplier bits, one per cycle
	localparam int CNT_W  = $clog2(BASE_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_MU_GO,
		ST_MU_WAIT
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/modexp_mulmod.sv
// Bit-serial modular multiplier: p = (a * b) mod m, one bit of b per cycle, MSB first.
// Depends on modexp_pkg.
`default_nettype none
module modexp_mulmod #(
	parameter int MW = 31
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         go,
	input  wire [MW-1:0]                a,
	input  wire [modexp_pkg::BASE_W-1:0] b,
	input  wire [MW-1:0]                m,
	output logic                        busy,
	output logic                        done,
	output logic [MW-1:0]               p
);

	logic                          run_q;
	logic                          done_q;
	logic [modexp_pkg::CNT_W-1:0]  cnt_q;
	logic [MW-1:0]                 r_q;
	logic [MW-1:0]                 a_q;
	logic [modexp_pkg::BASE_W-1:0] b_q;

	logic [MW+1:0] t;
	logic [MW+1:0] m1;
	logic [MW+1:0] m2;
	logic [MW+1:0] sel;

	// r < m and a < m (or a = 1), so 2r + a < 3m: at most one subtraction, of 2m or of m
	always_comb begin
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		t  = {1'b0, r_q, 1'b0} + (b_q[modexp_pkg::BASE_W-1] ? {2'b00, a_q} : '0);
		if (t >= m2) begin
			sel = t - m2;
		end else if (t >= m1) begin
			sel = t - m1;
		end else begin
			sel = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == modexp_pkg::CNT_W'(modexp_pkg::BASE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !run_q) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (run_q) begin
			r_q <= sel[MW-1:0];
			b_q <= {b_q[modexp_pkg::BASE_W-2:0], 1'b0};
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign p    = r_q;

endmodule
`default_nettype wire

FILE: hdl/modular_exponentiation.sv
// Top level: square-and-multiply sequencer around one bit-serial modular multiplier.
// Depends on modexp_pkg and modexp_mulmod.
`default_nettype none
// A request is taken when start is high and busy is low; busy stays high until the
// answer is ready, and power_result is valid for the single cycle in which done is
// high (it cannot be held off). Exponent zero gives 1 and modulus zero gives 0, in the
// cycle after the request. Otherwise the shared multiplier does all the work, one
// multiplier bit per cycle: one product to reduce the base, one squaring for every
// exponent bit (leading zeros included) and one extra product for every set bit.
module modular_exponentiation #(
	parameter int EXP_WIDTH = 32,
	parameter int MOD_WIDTH = 31
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [modexp_pkg::BASE_W-1:0] base_value,
	input  wire [EXP_WIDTH-1:0]          exponent,
	input  wire [MOD_WIDTH-1:0]          modulus,
	output logic                         done,
	output logic [modexp_pkg::RES_W-1:0] power_result
);

	localparam int BC_W = $clog2(EXP_WIDTH + 1);

	modexp_pkg::state_t state_q, state_d;

	logic [modexp_pkg::BASE_W-1:0] base_q;
	logic [EXP_WIDTH-1:0]          exp_q;
	logic [MOD_WIDTH-1:0]          mod_q;
	logic [MOD_WIDTH-1:0]          bred_q;
	logic [MOD_WIDTH-1:0]          acc_q;
	logic [BC_W-1:0]               bit_cnt_q;
	logic                          done_q;
	logic [modexp_pkg::RES_W-1:0]  power_result_q;

	logic                          accept;
	logic                          last_bit;
	logic                          mm_go;
	logic                          mm_busy;
	logic                          mm_done;
	logic [MOD_WIDTH-1:0]          mm_a;
	logic [modexp_pkg::BASE_W-1:0] mm_b;
	logic [MOD_WIDTH-1:0]          mm_p;

	assign accept   = start && (state_q == modexp_pkg::ST_IDLE);
	assign last_bit = (bit_cnt_q == BC_W'(1));

	modexp_mulmod #(
		.MW(MOD_WIDTH)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mm_go),
		.a     (mm_a),
		.b     (mm_b),
		.m     (mod_q),
		.busy  (mm_busy),
		.done  (mm_done),
		.p     (mm_p)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (start && (exponent != '0) && (modulus != '0)) begin
					state_d = modexp_pkg::ST_RED_GO;
				end
			end
			modexp_pkg::ST_RED_GO:   state_d = modexp_pkg::ST_RED_WAIT;
			modexp_pkg::ST_RED_WAIT: begin
				if (mm_done) begin
					state_d = modexp_pkg::ST_SQ_GO;
				end
			end
			modexp_pkg::ST_SQ_GO:    state_d = modexp_pkg::ST_SQ_WAIT;
			modexp_pkg::ST_SQ_WAIT: begin
				if (mm_done) begin
					if (exp_q[EXP_WIDTH-1]) begin
						state_d = modexp_pkg::ST_MU_GO;
					end else if (last_bit) begin
						state_d = modexp_pkg::ST_IDLE;
					end else begin
						state_d = modexp_pkg::ST_SQ_GO;
					end
				end
			end
			modexp_pkg::ST_MU_GO:    state_d = modexp_pkg::ST_MU_WAIT;
			modexp_pkg::ST_MU_WAIT: begin
				if (mm_done) begin
					state_d = last_bit ? modexp_pkg::ST_IDLE : modexp_pkg::ST_SQ_GO;
				end
			end
			default:                 state_d = modexp_pkg::ST_IDLE;
		endcase
	end

	// outputs and multiplier operands
	always_comb begin
		busy  = (state_q != modexp_pkg::ST_IDLE);
		mm_go = 1'b0;
		mm_a  = acc_q;
		mm_b  = modexp_pkg::BASE_W'(acc_q);
		unique case (state_q)
			modexp_pkg::ST_RED_GO: begin
				// base mod m computed as 1 * base
				mm_go = 1'b1;
				mm_a  = MOD_WIDTH'(1);
				mm_b  = base_q;
			end
			modexp_pkg::ST_SQ_GO: begin
				mm_go = 1'b1;
			end
			modexp_pkg::ST_MU_GO: begin
				mm_go = 1'b1;
				mm_a  = bred_q;
			end
			default: begin
				mm_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= modexp_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (accept && ((exponent == '0) || (modulus == '0))) begin
				done_q <= 1'b1;
			end else if (mm_done && (state_d == modexp_pkg::ST_IDLE)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q    <= base_value;
			exp_q     <= exponent;
			mod_q     <= modulus;
			acc_q     <= MOD_WIDTH'(1);
			bit_cnt_q <= BC_W'(EXP_WIDTH);
			if (exponent == '0) begin
				power_result_q <= modexp_pkg::RES_W'(1);
			end else begin
				power_result_q <= '0;
			end
		end else if (mm_done) begin
			unique case (state_q)
				modexp_pkg::ST_RED_WAIT: begin
					bred_q <= mm_p;
				end
				modexp_pkg::ST_SQ_WAIT: begin
					acc_q <= mm_p;
					if (!exp_q[EXP_WIDTH-1]) begin
						exp_q          <= exp_q << 1;
						bit_cnt_q      <= bit_cnt_q - 1'b1;
						power_result_q <= modexp_pkg::RES_W'(mm_p);
					end
				end
				modexp_pkg::ST_MU_WAIT: begin
					acc_q          <= mm_p;
					exp_q          <= exp_q << 1;
					bit_cnt_q      <= bit_cnt_q - 1'b1;
					power_result_q <= modexp_pkg::RES_W'(mm_p);
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign power_result = power_result_q;

`ifndef SYNTH
	// the multiplier is only launched when it is free
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mm_go |-> !mm_busy)
		else $error("multiplier launched while running");

	// a finished product always lands in a waiting state
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == modexp_pkg::ST_RED_WAIT ||
			state_q == modexp_pkg::ST_SQ_WAIT || state_q == modexp_pkg::ST_MU_WAIT))
		else $error("multiplier result outside a wait state");

	// reduced base stays below the modulus for every multiply step
	a_bred_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == modexp_pkg::ST_MU_GO) |-> (bred_q < mod_q))
		else $error("reduced base not below modulus");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_modular_exponentiation.sv
// Testbench for modular_exponentiation: directed corner cases, then random requests,
// each answer checked against a square-and-multiply predictor held in the bench.
// Depends on modexp_pkg and the modular_exponentiation RTL.
`default_nettype none
module tb_modular_exponentiation;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BASE_W = modexp_pkg::BASE_W;
	localparam int RES_W  = modexp_pkg::RES_W;
	localparam int EXP_W = 32;
	localparam int MOD_W = 31;
	localparam logic [BASE_W-1:0] BASE_MAX = '1;
	localparam logic [EXP_W-1:0]  EXP_MAX  = '1;
	localparam logic [MOD_W-1:0]  MOD_MAX  = '1;

	typedef struct {
		logic [RES_W-1:0]  power;
		logic [BASE_W-1:0] base;
		logic [EXP_W-1:0]  expo;
		logic [MOD_W-1:0]  modu;
	} power_req_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [BASE_W-1:0] base_value;
	logic [EXP_W-1:0]  exponent;
	logic [MOD_W-1:0]  modulus;
	logic              done;
	logic [RES_W-1:0]  power_result;

	power_req_t pending_powers[$];
	int         n_requests;
	int         n_results;
	int         n_zero_exp;
	int         n_errors;
	bit         no_idle;

	modular_exponentiation #(
		.EXP_WIDTH(EXP_W),
		.MOD_WIDTH(MOD_W)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.base_value  (base_value),
		.exponent    (exponent),
		.modulus     (modulus),
		.done        (done),
		.power_result(power_result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// base^expo mod modu, MSB first; every reduced value stays below 2^31
	function automatic logic [RES_W-1:0] predict_power(input logic [BASE_W-1:0] b,
			input logic [EXP_W-1:0] e, input logic [MOD_W-1:0] m);
		logic [63:0] acc;
		logic [63:0] b_red;
		logic [63:0] m64;
		if (e == '0)
			return RES_W'(1);
		if (m == '0)
			return '0;
		m64   = 64'(m);
		b_red = 64'(b) % m64;
		acc   = 64'd1;
		for (int i = EXP_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % m64;
			if (e[i])
				acc = (acc * b_red) % m64;
		end
		return acc[RES_W-1:0];
	endfunction

	// one request: optional idle gap, then hold start until busy is low at an edge
	task automatic send_request(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
			input logic [MOD_W-1:0] m);
		int         gap;
		power_req_t req;
		gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start      <= 1'b1;
		base_value <= b;
		exponent   <= e;
		modulus    <= m;
		do @(posedge clk); while (busy);
		req.power = predict_power(b, e, m);
		req.base  = b;
		req.expo  = e;
		req.modu  = m;
		pending_powers.push_back(req);
		n_requests++;
		if (e == '0)
			n_zero_exp++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (pending_powers.size() == 0) begin
				$error("power_result %0d arrived with no request outstanding", power_result);
				n_errors++;
			end else begin
				if (power_result !== pending_powers[0].power) begin
					$error("power_result mismatch: expected %0d, actual %0d (base %0d exp %0d mod %0d)",
						pending_powers[0].power, power_result, pending_powers[0].base,
						pending_powers[0].expo, pending_powers[0].modu);
					n_errors++;
				end
				void'(pending_powers.pop_front());
			end
		end
	end

	task automatic test_exponent_zero();
		send_request(31'd5, '0, 31'd7);
		send_request('0, '0, 31'd1);
		send_request(BASE_MAX, '0, MOD_MAX);
		send_request(31'd123, '0, 31'd1);
	endtask

	task automatic test_modulus_one();
		send_request(31'd12345, 32'd1, 31'd1);
		send_request(BASE_MAX, EXP_MAX, 31'd1);
	endtask

	task automatic test_extremes();
		send_request('0, 32'd5, 31'd13);
		send_request(BASE_MAX, EXP_MAX, MOD_MAX);
		send_request(BASE_MAX, 32'd1, MOD_MAX);   // base reduces to zero
		send_request(BASE_MAX - 31'd1, EXP_MAX, MOD_MAX);
		send_request('0, EXP_MAX, MOD_MAX);
		send_request(31'd100, 32'd1, 31'd7);
		send_request(BASE_MAX, EXP_MAX, 31'd2);
		send_request(31'h4000_0000, 32'h5555_5555, MOD_MAX - 31'd1);
		send_request(31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555);
		send_request(31'd1, EXP_MAX, 31'd3);
	endtask

	// single set bit in the exponent, at the top, at the bottom or in between
	task automatic test_leading_zeros();
		send_request(31'd3, 32'h8000_0000, 31'd1000003);
		send_request(31'd7, 32'd2, 31'd11);
		send_request(31'd2, 32'd1, MOD_MAX);
		send_request(BASE_MAX, 32'h0001_0000, 31'h4000_0001);
	endtask

	task automatic test_random(input int n);
		logic [MOD_W-1:0]  m;
		logic [BASE_W-1:0] b;
		logic [EXP_W-1:0]  e;
		for (int k = 0; k < n; k++) begin
			// every third stretch of 30 requests runs without idle gaps
			no_idle = ((k / 30) % 3) == 1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: m = MOD_W'($urandom_range(1, 32'h7FFF_FFFF));
				4, 5:       m = MOD_W'($urandom_range(1, 64));
				6:          m = MOD_MAX - MOD_W'($urandom_range(0, 15));
				7:          m = MOD_W'(32'd1 << $urandom_range(0, 30));
				default:    m = MOD_W'($urandom() >> $urandom_range(1, 31));
			endcase
			if (m == '0)
				m = MOD_W'(1);
			case ($urandom_range(0, 7))
				0, 1, 2, 3: b = BASE_W'($urandom());
				4, 5:       b = BASE_W'($urandom_range(0, 32'(m) - 1));
				6:          b = BASE_W'($urandom_range(0, 2));
				default:    b = BASE_MAX - BASE_W'($urandom_range(0, 3));
			endcase
			case ($urandom_range(0, 15))
				0:                e = '0;
				1, 2, 3:          e = EXP_W'($urandom_range(1, 40));
				4, 5, 6:          e = $urandom() >> $urandom_range(1, 31);
				7:                e = EXP_MAX;
				default:          e = $urandom();
			endcase
			send_request(b, e, m);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		base_value = '0;
		exponent   = '0;
		modulus    = MOD_W'(1);
		no_idle    = 1'b0;
		n_requests = 0;
		n_results  = 0;
		n_zero_exp = 0;
		n_errors   = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_exponent_zero();
		test_modulus_one();
		test_extremes();
		test_leading_zeros();
		test_random(270);

		@(negedge clk);
		start <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("%0d requests sent, %0d results checked (%0d with exponent zero);",
			n_requests, n_results, n_zero_exp);
		$display("covered corner operands, moduli from 1 to full width and random idle gaps.");
		if (n_errors == 0 && pending_powers.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// overall timeout, well above the worst case for all requests
	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
